[design/assert_macros.svh]
// Assertion macros shared by the matrix inverse RTL.
// Needs nothing else; include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define M3I_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define M3I_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[design/m3i_pkg.sv]
// Types and width constants for the 3x3 matrix inverse.
// No dependencies.
`default_nettype none
package m3i_pkg;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int NEL    = 9;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ADJ_W  = PROD_W + 1;
  localparam int LO_W   = DATA_W + 1;           // low slice of adj for split multiply
  localparam int PL_W   = DATA_W + LO_W + 1;
  localparam int DET_W  = DATA_W + ADJ_W + 2;   // sum of three terms
  localparam int NUM_W  = ADJ_W + 2 * FRAC_W;
  localparam int CMP_W  = (NUM_W > DET_W + DATA_W) ? NUM_W : DET_W + DATA_W;
  localparam int QD     = 4;
  localparam int QA_W   = $clog2(QD);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [PL_W-1:0]   pl_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DET_W-1:0]         mag_t;
  typedef logic [NUM_W-1:0]         num_t;

  typedef struct packed {
    num_t [NEL-1:0]   num;
    logic [NEL-1:0]   neg;
    logic [NEL-1:0]   ovf;
    mag_t             dmag;
    logic             singular;
  } qent_t;

  typedef struct packed {
    logic [NEL-1:0] neg;
    logic [NEL-1:0] ovf;
    logic           singular;
  } meta_t;
endpackage
`default_nettype wire

[design/m3i_front.sv]
// Front pipeline: adjugate, determinant, signs and overflow pre-check.
// Depends on m3i_pkg.
`default_nettype none
module m3i_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire m3i_pkg::data_t [m3i_pkg::NEL-1:0] m,
  output logic                               push,
  output m3i_pkg::qent_t                     push_data,
  input  wire logic                          q_full
);
  import m3i_pkg::*;
  localparam int NST = 7;
  localparam int CF_A [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CF_B [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CF_C [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CF_D [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic [NST-1:0] v_r;
  logic           en;
  prod_t p_r [NEL], s_r [NEL];
  data_t row1_r [3], row2_r [3];
  adj_t  adj2_r [NEL], adj3_r [NEL], adj4_r [NEL], adj5_r [NEL];
  pl_t   pl_r [3];
  prod_t ph_r [3];
  det_t  term_r [3];
  det_t  det_r;
  mag_t  dmag_r;
  num_t  num_r [NEL];
  logic [NEL-1:0] neg_r;
  logic  sing_r;
  qent_t ent_r;

  assign en        = !(v_r[NST-1] && q_full);
  assign in_ready  = en;
  assign push      = v_r[NST-1] && !q_full;
  assign push_data = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        p_r[i]    <= m[CF_A[i]] * m[CF_B[i]];
        s_r[i]    <= m[CF_C[i]] * m[CF_D[i]];
        adj2_r[i] <= ADJ_W'(p_r[i]) - ADJ_W'(s_r[i]);
        adj3_r[i] <= adj2_r[i];
        adj4_r[i] <= adj3_r[i];
        adj5_r[i] <= adj4_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        row1_r[k] <= m[k];
        row2_r[k] <= row1_r[k];
        // split the wide multiply: signed high part and unsigned low slice
        pl_r[k]   <= row2_r[k] * $signed({1'b0, adj2_r[3*k][LO_W-1:0]});
        ph_r[k]   <= row2_r[k] * $signed(adj2_r[3*k][ADJ_W-1:LO_W]);
        term_r[k] <= (DET_W'(ph_r[k]) <<< LO_W) + DET_W'(pl_r[k]);
      end
      det_r  <= term_r[0] + term_r[1] + term_r[2];
      dmag_r <= det_r[DET_W-1] ? mag_t'(-det_r) : mag_t'(det_r);
      sing_r <= (det_r == '0);
      for (int i = 0; i < NEL; i++) begin
        neg_r[i] <= adj5_r[i][ADJ_W-1] ^ det_r[DET_W-1];
        num_r[i] <= {(adj5_r[i][ADJ_W-1] ? ADJ_W'(-adj5_r[i]) : ADJ_W'(adj5_r[i])),
                     {(2*FRAC_W){1'b0}}};
      end
      for (int i = 0; i < NEL; i++) begin
        ent_r.num[i] <= num_r[i];
        // quotient of 2^DATA_W or more cannot fit: flag it before dividing
        ent_r.ovf[i] <= CMP_W'(num_r[i]) >= (CMP_W'(dmag_r) << DATA_W);
      end
      ent_r.neg      <= neg_r;
      ent_r.dmag     <= dmag_r;
      ent_r.singular <= sing_r;
    end
  end
endmodule
`default_nettype wire

[design/m3i_fifo.sv]
// Short queue between front and back halves.
// Depends on m3i_pkg and assert_macros.svh.
`default_nettype none
module m3i_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire m3i_pkg::qent_t push_data,
  input  wire logic           pop,
  output m3i_pkg::qent_t      head,
  output logic                full,
  output logic                empty
);
  import m3i_pkg::*;
  `include "assert_macros.svh"

  qent_t mem_r [QD];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QA_W:0]   cnt_r;

  assign full  = (cnt_r == (QA_W+1)'(QD));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QA_W+1)'(push) - (QA_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  `M3I_ASSERT_IMP(a_no_overrun, clk, rst_n, push, !full)
  `M3I_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, !empty)
  `M3I_ASSERT_NXT(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= (QA_W+1)'(QD))
endmodule
`default_nettype wire

[design/m3i_div_lane.sv]
// One restoring divider lane, one quotient bit per pipeline stage.
// Depends on m3i_pkg; caller guarantees quotient below 2^DATA_W.
`default_nettype none
module m3i_div_lane (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire m3i_pkg::num_t num,
  input  wire m3i_pkg::mag_t den,
  output logic [m3i_pkg::DATA_W-1:0] quo
);
  import m3i_pkg::*;
  localparam int RHI_W = NUM_W - DATA_W;

  mag_t              rem_r [DATA_W];
  mag_t              den_r [DATA_W];
  logic [DATA_W-1:0] low_r [DATA_W];
  logic [DATA_W-1:0] q_r   [DATA_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DATA_W; s++) begin
        logic [DET_W:0]    sh;
        logic              ge;
        mag_t              rin, din;
        logic [DATA_W-1:0] lin, qin;
        if (s == 0) begin
          rin = {{(DET_W-RHI_W){1'b0}}, num[NUM_W-1:DATA_W]};
          din = den;
          lin = num[DATA_W-1:0];
          qin = '0;
        end else begin
          rin = rem_r[s-1];
          din = den_r[s-1];
          lin = low_r[s-1];
          qin = q_r[s-1];
        end
        sh = {rin, lin[DATA_W-1]};
        ge = sh >= {1'b0, din};
        rem_r[s] <= ge ? DET_W'(sh - {1'b0, din}) : DET_W'(sh);
        den_r[s] <= din;
        low_r[s] <= lin << 1;
        q_r[s]   <= {qin[DATA_W-2:0], ge};
      end
    end
  end

  assign quo = q_r[DATA_W-1];
endmodule
`default_nettype wire

[design/m3i_back.sv]
// Back half: nine divider lanes, sign, saturation, singular zeroing and output register.
// Depends on m3i_pkg, m3i_div_lane and assert_macros.svh.
`default_nettype none
module m3i_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire m3i_pkg::qent_t head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output m3i_pkg::data_t [m3i_pkg::NEL-1:0] out_inv,
  output logic                out_singular,
  output logic                out_saturated
);
  import m3i_pkg::*;
  `include "assert_macros.svh"
  localparam logic [DATA_W-1:0] HALF = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] HMAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic              en;
  logic [DATA_W-1:0] dv_r;
  meta_t             meta_r [DATA_W];
  logic [DATA_W-1:0] quo [NEL];
  logic              ov_r;
  data_t [NEL-1:0]   inv_r;
  logic              sing_r, sat_r;

  assign en  = !(ov_r && !out_ready);
  assign pop = en && !q_empty;

  for (genvar i = 0; i < NEL; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (head.num[i]),
      .den (head.dmag),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      dv_r <= {dv_r[DATA_W-2:0], !q_empty};
      ov_r <= dv_r[DATA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= '{neg: head.neg, ovf: head.ovf, singular: head.singular};
      for (int s = 1; s < DATA_W; s++) meta_r[s] <= meta_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic sat_any;
      logic sl;
      meta_t mt;
      mt = meta_r[DATA_W-1];
      sat_any = 1'b0;
      for (int i = 0; i < NEL; i++) begin
        sl = mt.ovf[i] || (quo[i] > (mt.neg[i] ? HALF : HMAX));
        if (mt.singular) begin
          inv_r[i] <= '0;
        end else if (sl) begin
          inv_r[i] <= mt.neg[i] ? HALF : HMAX;
        end else begin
          inv_r[i] <= mt.neg[i] ? -quo[i] : quo[i];
        end
        sat_any = sat_any || sl;
      end
      sing_r <= mt.singular;
      sat_r  <= sat_any && !mt.singular;
    end
  end

  assign out_valid     = ov_r;
  assign out_inv       = inv_r;
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

  `M3I_ASSERT_IMP(a_sing_clean, clk, rst_n, ov_r && sing_r, !sat_r && inv_r == '0)
  `M3I_ASSERT_NXT(a_stall_hold, clk, rst_n, !en, ov_r && $stable(dv_r))
endmodule
`default_nettype wire

[design/matrix3_inverse_core.sv]
// 3x3 matrix inverse, one fixed-point matrix per beat, streaming.
// Depends on m3i_pkg, m3i_front, m3i_fifo, m3i_back.
//
// Usage:
//   Input channel in_valid/in_ready carries nine signed Q16.16 elements
//   in row-major order. Output channel out_valid/out_ready returns the nine
//   inverse elements, truncated toward zero and clipped to Q16.16, plus
//   out_singular (zero determinant, all elements zero) and out_saturated
//   (some element clipped).
//   Throughput: one matrix per cycle when the output is not stalled.
//   The front half (products, adjugate, determinant, overflow pre-check)
//   is 7 stages; a 4-entry queue follows; the back half has a 32-stage
//   restoring divider per element (one quotient bit per stage) and an
//   output register.
//   Reset (rst_n low, synchronous) empties all pipelines and the queue.
//   When out_ready is low with a beat waiting at the output, the back half
//   freezes; the queue absorbs beats until full, then in_ready drops and
//   the front half freezes too.
`default_nettype none
module matrix3_inverse_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire m3i_pkg::data_t in_r1c1,
  input  wire m3i_pkg::data_t in_r1c2,
  input  wire m3i_pkg::data_t in_r1c3,
  input  wire m3i_pkg::data_t in_r2c1,
  input  wire m3i_pkg::data_t in_r2c2,
  input  wire m3i_pkg::data_t in_r2c3,
  input  wire m3i_pkg::data_t in_r3c1,
  input  wire m3i_pkg::data_t in_r3c2,
  input  wire m3i_pkg::data_t in_r3c3,
  output logic                out_valid,
  input  wire logic           out_ready,
  output m3i_pkg::data_t      out_inv_r1c1,
  output m3i_pkg::data_t      out_inv_r1c2,
  output m3i_pkg::data_t      out_inv_r1c3,
  output m3i_pkg::data_t      out_inv_r2c1,
  output m3i_pkg::data_t      out_inv_r2c2,
  output m3i_pkg::data_t      out_inv_r2c3,
  output m3i_pkg::data_t      out_inv_r3c1,
  output m3i_pkg::data_t      out_inv_r3c2,
  output m3i_pkg::data_t      out_inv_r3c3,
  output logic                out_singular,
  output logic                out_saturated
);
  import m3i_pkg::*;

  data_t [NEL-1:0] m;
  data_t [NEL-1:0] inv;
  logic  push, pop, q_full, q_empty;
  qent_t push_data, head;

  assign m = {in_r3c3, in_r3c2, in_r3c1, in_r2c3, in_r2c2, in_r2c1,
              in_r1c3, in_r1c2, in_r1c1};

  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .m         (m),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  m3i_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  m3i_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inv       (inv),
    .out_singular  (out_singular),
    .out_saturated (out_saturated)
  );

  assign out_inv_r1c1 = inv[0];
  assign out_inv_r1c2 = inv[1];
  assign out_inv_r1c3 = inv[2];
  assign out_inv_r2c1 = inv[3];
  assign out_inv_r2c2 = inv[4];
  assign out_inv_r2c3 = inv[5];
  assign out_inv_r3c1 = inv[6];
  assign out_inv_r3c2 = inv[7];
  assign out_inv_r3c3 = inv[8];
endmodule
`default_nettype wire

[bench/tb_matrix3_inverse_core.sv]
// Self-checking bench for matrix3_inverse_core: streams 3x3 Q16.16 matrices and
// checks each inverse beat against an exact big-integer prediction in order.
// Depends on m3i_pkg and the matrix3_inverse_core RTL.
`timescale 1ns / 1ps

module tb_matrix3_inverse_core;
  import m3i_pkg::*;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef struct {
    elem_t el [9];
    logic  singular;
    logic  saturated;
  } inv_res_t;

  class inverse_board;
    inv_res_t pending[$];
    int errors;
    int checked;
    int singular_seen;
    int sat_seen;

    // Exact adjugate / determinant, then truncated divide and clip.
    function void note_matrix(elem_t m [9]);
      logic signed [255:0] a [9];
      logic signed [255:0] adj [9];
      logic signed [255:0] det;
      logic signed [255:0] q;
      logic signed [255:0] hi;
      logic signed [255:0] lo;
      inv_res_t r;
      for (int i = 0; i < 9; i++) a[i] = m[i];
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      hi = (256'sd1 <<< (DATA_W - 1)) - 1;
      lo = -(256'sd1 <<< (DATA_W - 1));
      r.singular = (det == 0);
      r.saturated = 1'b0;
      for (int i = 0; i < 9; i++) begin
        if (r.singular) begin
          r.el[i] = '0;
        end else begin
          // SV signed division truncates toward zero
          q = (adj[i] <<< (2 * FRAC_W)) / det;
          if (q > hi) begin
            q = hi;
            r.saturated = 1'b1;
          end else if (q < lo) begin
            q = lo;
            r.saturated = 1'b1;
          end
          r.el[i] = q[DATA_W-1:0];
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_beat(inv_res_t got);
      inv_res_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.singular) singular_seen++;
      if (exp_r.saturated) sat_seen++;
      for (int i = 0; i < 9; i++)
        if (got.el[i] !== exp_r.el[i]) begin
          $error("inv_r%0dc%0d: expected %0d, got %0d", i / 3 + 1, i % 3 + 1,
                 exp_r.el[i], got.el[i]);
          errors++;
        end
      if (got.singular !== exp_r.singular) begin
        $error("singular: expected %0b, got %0b", exp_r.singular, got.singular);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated: expected %0b, got %0b", exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  elem_t in_e [9];
  logic out_valid;
  logic out_ready = 1'b0;
  elem_t out_e [9];
  logic out_singular, out_saturated;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  inverse_board board = new();

  initial for (int i = 0; i < 9; i++) in_e[i] = '0;

  always #10 clk = ~clk;

  matrix3_inverse_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r1c1(in_e[0]), .in_r1c2(in_e[1]), .in_r1c3(in_e[2]),
    .in_r2c1(in_e[3]), .in_r2c2(in_e[4]), .in_r2c3(in_e[5]),
    .in_r3c1(in_e[6]), .in_r3c2(in_e[7]), .in_r3c3(in_e[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inv_r1c1(out_e[0]), .out_inv_r1c2(out_e[1]), .out_inv_r1c3(out_e[2]),
    .out_inv_r2c1(out_e[3]), .out_inv_r2c2(out_e[4]), .out_inv_r2c3(out_e[5]),
    .out_inv_r3c1(out_e[6]), .out_inv_r3c2(out_e[7]), .out_inv_r3c3(out_e[8]),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    inv_res_t got;
    if (rst_n && out_valid && out_ready) begin
      for (int i = 0; i < 9; i++) got.el[i] = out_e[i];
      got.singular = out_singular;
      got.saturated = out_saturated;
      board.check_beat(got);
    end
    out_ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up after a beat until the next idle cycle or the drain
  task automatic send_matrix(input elem_t m [9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_e[i] <= m[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_matrix(m);
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(1, 8) <<< FRAC_W) * ($urandom_range(1) ? 1 : -1);
      2: return elem_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      4: return elem_t'($urandom_range(0, 1));
      default: return elem_t'(($signed($urandom) >>> $urandom_range(8, 20)));
    endcase
  endfunction

  task automatic send_random(input int n);
    elem_t m [9];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      // make some rows dependent so singular cases show up
      if ($urandom_range(9) == 0)
        for (int i = 0; i < 3; i++) m[6 + i] = m[i];
      send_matrix(m);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic directed();
    elem_t m [9];
    elem_t one;
    one = elem_t'(1 <<< FRAC_W);
    // identity
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};
    send_matrix(m);
    // zero matrix, singular
    m = '{default: 0};
    send_matrix(m);
    // repeated rows, singular
    m = '{one, 2 * one, 3 * one, one, 2 * one, 3 * one, 5, 6, 7};
    send_matrix(m);
    // tiny diagonal: huge inverse, clips positive
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    // clips negative
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    // extremes on every element
    m = '{default: 32'sh7fffffff};
    send_matrix(m);
    m = '{default: 32'sh80000000};
    send_matrix(m);
    m = '{32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh80000000};
    send_matrix(m);
    m = '{32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff, 0,
          0, 32'sh80000000, 32'sh7fffffff};
    send_matrix(m);
    m = '{-one, 0, 0, 0, 2 * one, 0, 0, 0, -4 * one};
    send_matrix(m);
    // truncation toward zero on thirds
    m = '{3 * one, 0, 0, 0, -3 * one, 0, 0, 0, 3 * one};
    send_matrix(m);
    m = '{2 * one, one, 0, one, 2 * one, one, 0, one, 2 * one};
    send_matrix(m);
    m = '{default: -1};
    send_matrix(m);
    m = '{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
          32'sh33333333, 32'shcccccccc, 32'sh00ff00ff, 32'shff00ff00, 32'sh12345678};
    send_matrix(m);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    send_random(350);
    send_idle_pct = 75;
    send_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    send_random(350);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    send_random(350);
    // long receiver hold-off so the queue fills and input backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(200);
    join
    send_random(330);
    drain();
    $display("Covered %0d matrices across idle/stall mixes: %0d singular, %0d clipped.",
             board.checked, board.singular_seen, board.sat_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
